// ===== design/cfd_pkg.sv =====
`timescale 1ns / 1ps

package cfd_pkg;

    localparam logic [7:0] HEADER_RESET = 8'h2E;
    localparam int         PADDR_W      = 3;
    localparam int         PDATA_W      = 32;

    // register map (byte address / 4)
    localparam logic REG_HEADER = 1'b0;

    localparam logic KIND_HEADING = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] command;
        logic [5:0] length;
        logic [7:0] data_byte;
        logic [4:0] byte_index;
        logic       last;
    } res_t;

    typedef struct packed {
        logic in_ready;
        logic cap_cmd;
        logic cap_len;
        logic store;
        logic load_head;
        logic load_data;
    } ctl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic is_hdr;
        logic rx_zero;
        logic too_big;
        logic fill_done;
        logic sum_ok;
        logic held_zero;
        logic drain_last;
        logic out_free;
    } ctl_sts_t;

endpackage

// ===== design/cfd_rx_if.sv =====
`timescale 1ns / 1ps

interface cfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/cfd_res_if.sv =====
`timescale 1ns / 1ps

interface cfd_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] command;
    logic [5:0] length;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic       last;

    modport source (output valid, output kind, output command, output length,
                    output data_byte, output byte_index, output last, input ready);
    modport sink (input valid, input kind, input command, input length,
                  input data_byte, input byte_index, input last, output ready);
endinterface

// ===== design/cfd_ram.sv =====
`timescale 1ns / 1ps

module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/cfd_ctrl.sv =====
`timescale 1ns / 1ps

module cfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfd_pkg::ctl_sts_t    sts,
    output cfd_pkg::ctl_cmd_t    cmd
);
    localparam logic [2:0] S_HDR  = 3'd0;
    localparam logic [2:0] S_CMD  = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_PAY  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_HEAD = 3'd5;
    localparam logic [2:0] S_DATA = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       acc;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cmd.in_ready = (state_reg == S_HDR) || (state_reg == S_CMD) ||
                       (state_reg == S_LEN) || (state_reg == S_PAY) ||
                       (state_reg == S_CHK);
        acc = sts.in_valid && cmd.in_ready;
        unique case (state_reg)
            S_HDR:
            begin
                if (acc && sts.is_hdr)
                    state_next = S_CMD;
            end
            S_CMD:
            begin
                cmd.cap_cmd = acc;
                if (acc)
                    state_next = S_LEN;
            end
            S_LEN:
            begin
                cmd.cap_len = acc;
                if (acc)
                begin
                    if (sts.too_big)
                        state_next = S_HDR;
                    else if (sts.rx_zero)
                        state_next = S_CHK;
                    else
                        state_next = S_PAY;
                end
            end
            S_PAY:
            begin
                cmd.store = acc;
                if (acc && sts.fill_done)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                if (acc)
                    state_next = sts.sum_ok ? S_HEAD : S_HDR;
            end
            S_HEAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_head = 1'b1;
                    state_next    = sts.held_zero ? S_HDR : S_DATA;
                end
            end
            S_DATA:
            begin
                if (sts.out_free)
                begin
                    cmd.load_data = 1'b1;
                    if (sts.drain_last)
                        state_next = S_HDR;
                end
            end
            default:
            begin
                state_next = S_HDR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_HDR;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/cfd_datapath.sv =====
`timescale 1ns / 1ps

module cfd_datapath #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           header_byte,
    input  logic                 in_valid,
    input  logic [7:0]           rx_byte,
    input  logic                 out_ready,
    input  cfd_pkg::ctl_cmd_t    cmd,
    output cfd_pkg::ctl_sts_t    sts,
    output logic                 out_valid,
    output cfd_pkg::res_t        out_res
);
    localparam int         AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [5:0] MAX_LEN = 6'(MAX_PAYLOAD);

    logic [7:0]    cmd_reg;
    logic [5:0]    len_reg;
    logic [5:0]    fill_reg;
    logic [7:0]    sum_reg;
    logic [5:0]    idx_reg;
    logic          out_valid_reg;
    cfd_pkg::res_t res_reg;

    logic [5:0]    fill_inc;
    logic [5:0]    idx_inc;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    assign fill_inc = fill_reg + 6'd1;
    assign idx_inc  = idx_reg + 6'd1;

    assign sts.in_valid   = in_valid;
    assign sts.is_hdr     = (rx_byte == header_byte);
    assign sts.rx_zero    = (rx_byte == 8'd0);
    assign sts.too_big    = (rx_byte > {2'b00, MAX_LEN});
    assign sts.fill_done  = (fill_inc >= len_reg);
    assign sts.sum_ok     = (rx_byte == ~sum_reg);
    assign sts.held_zero  = (len_reg == 6'd0);
    assign sts.drain_last = (idx_inc == len_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign ram_we    = cmd.store && (fill_reg < MAX_LEN);
    assign ram_re    = cmd.load_head || cmd.load_data;
    // heading prefetches entry 0, each payload result prefetches the next one
    assign ram_raddr = cmd.load_head ? '0 : idx_inc[AW-1:0];

    cfd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg  <= '0;
            len_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            if (cmd.cap_cmd)
            begin
                cmd_reg <= rx_byte;
                sum_reg <= rx_byte;
            end
            if (cmd.cap_len && !sts.too_big)
            begin
                len_reg  <= rx_byte[5:0];
                fill_reg <= '0;
                sum_reg  <= sum_reg + rx_byte;
            end
            if (cmd.store)
            begin
                fill_reg <= fill_inc;
                sum_reg  <= sum_reg + rx_byte;
            end
            if (cmd.load_head)
                idx_reg <= '0;
            else if (cmd.load_data)
                idx_reg <= idx_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_head || cmd.load_data)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_head)
        begin
            res_reg.kind       <= cfd_pkg::KIND_HEADING;
            res_reg.command    <= cmd_reg;
            res_reg.length     <= len_reg;
            res_reg.data_byte  <= 8'd0;
            res_reg.byte_index <= 5'd0;
            res_reg.last       <= sts.held_zero;
        end
        else if (cmd.load_data)
        begin
            res_reg.kind       <= cfd_pkg::KIND_PAYLOAD;
            res_reg.command    <= cmd_reg;
            res_reg.length     <= len_reg;
            res_reg.data_byte  <= ram_rdata;
            res_reg.byte_index <= idx_reg[4:0];
            res_reg.last       <= sts.drain_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_head || cmd.load_data) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (fill_reg < len_reg))
        else $error("payload write past frame length");

    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_data |-> (idx_reg < len_reg))
        else $error("drain index past frame length");

endmodule

// ===== design/checksum_frame_deframer_unit.sv =====
`timescale 1ns / 1ps

// Byte-serial deframer for frames of header, command, length, payload and
// checksum (one's complement of the 8-bit sum of command, length and payload).
// While parsing, one received byte is taken every cycle. After a good checksum
// the input stalls while the result run drains: one heading, then one result
// per payload byte, one per cycle while the result side takes them, paced by
// the single read port of the payload store. A frame with N payload bytes thus
// takes N+4 received bytes and gives N+1 results. Bad or oversized frames
// emit nothing and the search restarts at the header byte, which is set
// through the APB register at address 0 (reset 0x2E).
module checksum_frame_deframer_unit #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cfd_rx_if.sink                        rx,
    cfd_res_if.source                     res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfd_pkg::PADDR_W-1:0]   paddr,
    input  logic [cfd_pkg::PDATA_W-1:0]   pwdata,
    output logic [cfd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    logic [7:0]        header_reg;
    logic              cfg_wr;
    cfd_pkg::ctl_cmd_t cmd;
    cfd_pkg::ctl_sts_t sts;
    cfd_pkg::res_t     out_res;
    logic              out_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cfd_pkg::REG_HEADER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_reg <= cfd_pkg::HEADER_RESET;
        else if (cfg_wr)
            header_reg <= pwdata[7:0];
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            cfd_pkg::REG_HEADER: prdata = {24'd0, header_reg};
            default:             prdata = '0;
        endcase
    end

    cfd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    cfd_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .header_byte (header_reg),
        .in_valid    (rx.valid),
        .rx_byte     (rx.rx_byte),
        .out_ready   (res.ready),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_res     (out_res)
    );

    assign rx.ready       = cmd.in_ready;
    assign res.valid      = out_valid;
    assign res.kind       = out_res.kind;
    assign res.command    = out_res.command;
    assign res.length     = out_res.length;
    assign res.data_byte  = out_res.data_byte;
    assign res.byte_index = out_res.byte_index;
    assign res.last       = out_res.last;

endmodule

// ===== verif/checksum_frame_deframer_unit_tb.sv =====
`timescale 1ns / 1ps

module checksum_frame_deframer_unit_tb;

    localparam int FRAME_MAX   = 32;
    localparam int CYCLE_LIMIT = 100000;
    localparam int IDLE_SLACK  = 4;
    localparam int END_SLACK   = 40;
    localparam int PADDR_W     = cfd_pkg::PADDR_W;
    localparam int PDATA_W     = cfd_pkg::PDATA_W;
    localparam logic [PADDR_W-1:0] HEADER_ADDR = PADDR_W'(int'(cfd_pkg::REG_HEADER) * 4);

    typedef enum logic [2:0] {
        SEEK_HEADER,
        GET_COMMAND,
        GET_LENGTH,
        GET_PAYLOAD,
        GET_CHECKSUM
    } frame_phase_e;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    cfd_rx_if  rx_ch ();
    cfd_res_if res_ch ();

    checksum_frame_deframer_unit #(
        .MAX_PAYLOAD(FRAME_MAX)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // frame parser mirror
    logic [7:0]   parse_hdr;
    frame_phase_e parse_phase;
    logic [7:0]   parse_cmd;
    logic [5:0]   parse_len;
    logic [5:0]   parse_fill;
    logic [7:0]   parse_sum;
    logic [7:0]   parse_store [FRAME_MAX];

    cfd_pkg::res_t expected_results [$];
    cfd_pkg::res_t want;

    bit idle_on;
    int mismatch_count;
    int results_checked;
    int rx_bytes_sent;
    int noise_bytes;
    int frames_sent;
    int frames_good;
    int cycle_count;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void predict_rx_byte(input logic [7:0] b);
        cfd_pkg::res_t r;
        int            i;
        case (parse_phase)
            SEEK_HEADER:
            begin
                if (b == parse_hdr)
                    parse_phase = GET_COMMAND;
            end
            GET_COMMAND:
            begin
                parse_cmd   = b;
                parse_sum   = b;
                parse_phase = GET_LENGTH;
            end
            GET_LENGTH:
            begin
                if (b == 8'd0)
                begin
                    parse_len   = 6'd0;
                    parse_fill  = 6'd0;
                    parse_phase = GET_CHECKSUM;
                end
                else if (b <= FRAME_MAX)
                begin
                    parse_len   = b[5:0];
                    parse_fill  = 6'd0;
                    parse_sum   = parse_sum + b;
                    parse_phase = GET_PAYLOAD;
                end
                else
                    parse_phase = SEEK_HEADER;
            end
            GET_PAYLOAD:
            begin
                parse_store[parse_fill[4:0]] = b;
                parse_sum  = parse_sum + b;
                parse_fill = parse_fill + 6'd1;
                if (parse_fill >= parse_len)
                    parse_phase = GET_CHECKSUM;
            end
            GET_CHECKSUM:
            begin
                if (b == ~parse_sum)
                begin
                    r.kind       = cfd_pkg::KIND_HEADING;
                    r.command    = parse_cmd;
                    r.length     = parse_len;
                    r.data_byte  = 8'd0;
                    r.byte_index = 5'd0;
                    r.last       = (parse_len == 6'd0);
                    expected_results.push_back(r);
                    for (i = 0; i < int'(parse_len); i++)
                    begin
                        r.kind       = cfd_pkg::KIND_PAYLOAD;
                        r.data_byte  = parse_store[i];
                        r.byte_index = i[4:0];
                        r.last       = (i + 1 == int'(parse_len));
                        expected_results.push_back(r);
                    end
                end
                parse_phase = SEEK_HEADER;
            end
            default:
                parse_phase = SEEK_HEADER;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (exp_v !== got_v)
        begin
            mismatch_count++;
            $display("%0t: %s expected 0x%02h got 0x%02h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result expected none got kind=%0d cmd=0x%02h len=%0d",
                         $time, res_ch.kind, res_ch.command, res_ch.length);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", 8'(want.kind), 8'(res_ch.kind));
                check_field("command", want.command, res_ch.command);
                check_field("length", 8'(want.length), 8'(res_ch.length));
                check_field("data_byte", want.data_byte, res_ch.data_byte);
                check_field("byte_index", 8'(want.byte_index), 8'(res_ch.byte_index));
                check_field("last", 8'(want.last), 8'(res_ch.last));
                results_checked++;
            end
        end
    end

    // result side backpressure
    initial
    begin
        int stall;
        stall = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                res_ch.ready = 1'b0;
                stall--;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                res_ch.ready = 1'b0;
                stall = $urandom_range(1, 11) - 1;
            end
            else
                res_ch.ready = 1'b1;
        end
    end

    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            rx_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        do @(posedge clk); while (!rx_ch.ready);
        predict_rx_byte(b);
        rx_bytes_sent++;
    endtask

    // drop valid, wait for every pending result, then let the parser settle
    task automatic settle_idle(input int slack);
        @(negedge clk);
        rx_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (slack) @(posedge clk);
    endtask

    task automatic reg_read_check(input logic [7:0] exp_v);
        logic [7:0] got;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = HEADER_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata[7:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        check_field("header_byte readback", exp_v, got);
    endtask

    task automatic reg_write(input logic [7:0] v);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = HEADER_ADDR;
        pwdata  = {24'd0, v};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        parse_hdr = v;
        reg_read_check(v);
    endtask

    // 0 <= cut < length stops the payload early, leaving the parser mid-frame
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len_byte,
                              input bit bad_sum, input int cut);
        logic [7:0] sum;
        logic [7:0] pay;
        int         n;
        int         i;
        frames_sent++;
        send_rx_byte(parse_hdr);
        send_rx_byte(cmd);
        send_rx_byte(len_byte);
        if (len_byte > FRAME_MAX)
            return;
        sum = cmd + len_byte;
        n = int'(len_byte);
        if (cut >= 0 && cut < n)
            n = cut;
        for (i = 0; i < n; i++)
        begin
            pay = ($urandom_range(0, 7) == 0) ? parse_hdr : 8'($urandom_range(0, 255));
            sum = sum + pay;
            send_rx_byte(pay);
        end
        if (cut >= 0 && cut < int'(len_byte))
            return;
        sum = ~sum;
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        else
            frames_good++;
        send_rx_byte(sum);
    endtask

    task automatic send_fixed_frame(input logic [7:0] cmd, input logic [7:0] pl [$],
                                    input bit bad_sum);
        logic [7:0] sum;
        int         i;
        frames_sent++;
        send_rx_byte(parse_hdr);
        send_rx_byte(cmd);
        send_rx_byte(8'(pl.size()));
        sum = cmd + 8'(pl.size());
        for (i = 0; i < pl.size(); i++)
        begin
            sum = sum + pl[i];
            send_rx_byte(pl[i]);
        end
        sum = ~sum;
        if (bad_sum)
            sum = sum ^ 8'h5A;
        else
            frames_good++;
        send_rx_byte(sum);
    endtask

    task automatic random_frame();
        int         pick;
        int         len;
        int         k;
        logic [7:0] cmd;
        pick = $urandom_range(0, 99);
        cmd  = 8'($urandom_range(0, 255));
        if (pick < 8)
        begin
            k = $urandom_range(1, 3);
            repeat (k)
            begin
                send_rx_byte(($urandom_range(0, 3) == 0) ? parse_hdr
                                                        : 8'($urandom_range(0, 255)));
                noise_bytes++;
            end
        end
        else if (pick < 14)
            send_frame(cmd, 8'($urandom_range(FRAME_MAX + 1, 255)), 1'b0, -1);
        else if (pick < 22)
            send_frame(cmd, 8'($urandom_range(0, 8)), 1'b1, -1);
        else if (pick < 28)
        begin
            len = $urandom_range(2, 10);
            send_frame(cmd, 8'(len), 1'b0, $urandom_range(0, len - 1));
        end
        else if (pick < 33)
            send_frame(cmd, 8'($urandom_range(FRAME_MAX - 4, FRAME_MAX)), 1'b0, -1);
        else
            send_frame(cmd, 8'($urandom_range(0, 8)), 1'b0, -1);
    endtask

    task automatic run_random(input int n_bytes);
        int stop_at;
        stop_at = rx_bytes_sent - noise_bytes + n_bytes;
        while (rx_bytes_sent - noise_bytes < stop_at)
            random_frame();
    endtask

    task automatic test_register_reset();
        reg_read_check(cfd_pkg::HEADER_RESET);
    endtask

    task automatic test_directed_frames();
        logic [7:0] pl [$];
        pl = {};
        send_fixed_frame(8'hFF, pl, 1'b0);          // zero length, heading only
        pl = {cfd_pkg::HEADER_RESET};
        send_fixed_frame(8'h00, pl, 1'b0);          // header byte as payload
        send_frame(8'h3C, 8'(FRAME_MAX + 1), 1'b0, -1);  // just over the limit
        pl = {};
        send_fixed_frame(8'h81, pl, 1'b1);          // bad checksum
        pl = {8'hFF, 8'h00};
        send_fixed_frame(8'h7E, pl, 1'b0);
        settle_idle(IDLE_SLACK);
    endtask

    task automatic test_header_settings();
        logic [7:0] hdrs [3];
        int         h;
        hdrs[0] = 8'h00;
        hdrs[1] = 8'hFF;
        hdrs[2] = 8'($urandom_range(1, 254));
        for (h = 0; h < 3; h++)
        begin
            reg_write(hdrs[h]);
            repeat (2) random_frame();
            settle_idle(IDLE_SLACK);
        end
        reg_write(cfd_pkg::HEADER_RESET);
    endtask

    task automatic test_random_traffic();
        run_random(40);
        settle_idle(IDLE_SLACK);
    endtask

    // sender holds off until the whole run of results has drained
    task automatic test_drain_pause();
        repeat (5)
        begin
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(1, 6)), 1'b0, -1);
            settle_idle(0);
        end
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        send_frame(8'($urandom_range(0, 255)), 8'(FRAME_MAX), 1'b0, -1);
        run_random(24);
        settle_idle(END_SLACK);
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = 8'd0;
        idle_on         = 1'b1;
        mismatch_count  = 0;
        results_checked = 0;
        rx_bytes_sent   = 0;
        noise_bytes     = 0;
        frames_sent     = 0;
        frames_good     = 0;
        cycle_count     = 0;
        parse_hdr       = cfd_pkg::HEADER_RESET;
        parse_phase     = SEEK_HEADER;
        parse_cmd       = 8'd0;
        parse_len       = 6'd0;
        parse_fill      = 6'd0;
        parse_sum       = 8'd0;
        foreach (parse_store[i])
            parse_store[i] = 8'd0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_register_reset();
        test_directed_frames();
        test_header_settings();
        test_random_traffic();
        test_drain_pause();
        test_no_idle();

        $display("sent %0d bytes in %0d frames (%0d with good checksum), checked %0d results",
                 rx_bytes_sent, frames_sent, frames_good, results_checked);
        $display("header settings 0x2E, 0x00, 0xFF and one random; zero, max, oversize, "
                 , "bad-sum and cut-short frames");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
